FILE: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, constants and round functions of the sha-256 block compressor
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int WordWidth    = 32;
    localparam int WindowDepth  = 16;
    localparam int HashDepth    = 8;
    localparam int RoundCount   = 64;

    typedef logic [WordWidth-1:0] word_t;

    typedef struct packed {
        logic [31:0] msg_word;
        logic        first_word;
        logic        final_block;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } sha_state_t;

    // hand-off from sequencer to round datapath
    typedef struct packed {
        logic load_vars;
        logic do_round;
    } round_ctl_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        r = '0;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = '0;
        endcase
        return r;
    endfunction

    localparam word_t RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

FILE: hw/rtl/sha256_ram.sv
// ----------------------------------------------------------------------------
// sha256_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module sha256_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// working variables a..h and one compression round per cycle while ctl.do_round is set
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::round_ctl_t ctl,
    input  sha256_pkg::word_t      hash_in [8],
    input  sha256_pkg::word_t      kw,
    output sha256_pkg::word_t      vars [8]
);
    import sha256_pkg::*;

    word_t v_reg [8];
    word_t v_next [8];
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    always_comb
    begin
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + kw;
        t2  = big_sigma0(v_reg[0]) + maj;
        v_next = v_reg;
        if (ctl.load_vars)
        begin
            v_next = hash_in;
        end
        else if (ctl.do_round)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= '0;
            end
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign vars = v_reg;
endmodule

FILE: hw/rtl/sha256_block_compressor.sv
// ----------------------------------------------------------------------------
// sha256_block_compressor
// sha-256 compression of a padded word stream, digest out as eight words
// ----------------------------------------------------------------------------
// after a final block's sixteenth word is accepted, a..h are loaded, the rounds run
// and the add step updates the hash state, from which the digest words are emitted
// a block's 16 words are collected first, then load, rounds and add run on the
// single round unit; no word is taken meanwhile, nor while digest words emit
// reset: hash state takes the initial value, count and vars clear
module sha256_block_compressor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_word_t out_data
);
    import sha256_pkg::*;

    sha_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;       // words of the current block taken
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       final_reg, final_next;
    word_t      hash_reg [8];
    word_t      vars [8];
    round_ctl_t ctl;

    // schedule window ram: 16 words, message word w[t] of the block lives at t
    logic       ram_we;
    logic [3:0] ram_waddr;
    word_t      ram_wdata;
    logic [3:0] ram_raddr;
    word_t      ram_rdata;

    // last 16 schedule words shifted in registers for expansion taps
    word_t      w_reg [16];
    word_t      w_new;
    logic       accept;

    assign accept = in_valid && in_ready;

    sha256_ram #(.Width(WordWidth), .Depth(WindowDepth)) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // expanded word for round t >= 16 from the register window
    assign w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);

    word_t w_cur;
    assign w_cur = (rnd_reg < 6'd16) ? ram_rdata : w_new;

    sha256_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .hash_in (hash_reg),
        .kw      (RoundK[rnd_reg] + w_cur),
        .vars    (vars)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        final_next = final_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        ctl        = '0;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg;
        ram_wdata  = in_data.msg_word;
        ram_raddr  = 4'd0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready  = 1'b1;
                ram_waddr = in_data.first_word ? 4'd0 : cnt_reg;
                if (accept)
                begin
                    ram_we   = 1'b1;
                    cnt_next = ram_waddr + 4'd1;
                    if (ram_waddr == 4'd15)
                    begin
                        final_next = in_data.final_block;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                // prefetch w[0] and load a..h
                ctl.load_vars = 1'b1;
                ram_raddr     = 4'd0;
                rnd_next      = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                ctl.do_round = 1'b1;
                ram_raddr    = rnd_reg[3:0] + 4'd1;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                idx_next   = '0;
                state_next = final_reg ? ST_EMIT : ST_COLLECT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign out_data.digest_word = hash_reg[idx_reg];
    assign out_data.word_index  = idx_reg;
    assign out_data.last        = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            final_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            final_reg <= final_next;
            // a new message reloads the initial hash value
            if (accept && in_data.first_word)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= init_hash(3'(i));
                end
            end
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + vars[i];
                end
            end
        end
    end

    // schedule shift window, fed by ram words then expanded words
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_cur;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COLLECT) |-> !in_ready)
        else $error("word accepted while compressing");
    a_round_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_ROUND && rnd_reg == 6'd0))
        else $error("rounds did not start at zero");
    a_last_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last) |=> (state_reg == ST_COLLECT))
        else $error("emit did not end after last digest word");
endmodule
